/* sv/ffe_pkg.sv */
// ----------------------------------------------------------------------------
// ffe_pkg
// Types, constants and helpers for the form field extractor and decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ffe_pkg;

  localparam int ENCODED_BUFFER_BYTES = 1024;
  localparam int ENC_CNT_W            = $clog2(ENCODED_BUFFER_BYTES);
  localparam logic [ENC_CNT_W-1:0] ENC_MAX = ENC_CNT_W'(ENCODED_BUFFER_BYTES - 1);

  localparam int MAX_NAME_BYTES = 8;
  localparam int NAME_W         = 64;
  localparam int NAME_LEN_W     = 4;
  localparam int NAME_POS_W     = 4;
  localparam int LIMIT_W        = 10;
  localparam int CFG_IDX_W      = 2;
  localparam int RES_CNT_W      = 2;
  localparam int MAX_RES        = 3;

  localparam logic [NAME_LEN_W-1:0] NAME_LEN_MAX = NAME_LEN_W'(MAX_NAME_BYTES);

  localparam logic [NAME_W-1:0]     FIELD_NAME_RST  = '0;
  localparam logic [NAME_LEN_W-1:0] NAME_LEN_RST    = 4'd8;
  localparam logic [LIMIT_W-1:0]    VALUE_LIMIT_RST = 10'd511;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_NAME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_LIMIT = 2'd2;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_NAME  = 2'd0,
    PH_VALUE = 2'd1,
    PH_SKIP  = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_HEX1 = 2'd2
  } esc_t;

  // the results of one input byte, handed from front to back
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [RES_CNT_W-1:0]    cnt;
    logic                    found;
    logic                    done;
  } job_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/ffe_in_if.sv */
// ----------------------------------------------------------------------------
// ffe_in_if
// Input byte channel: one byte of form data and its end marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* sv/ffe_out_if.sv */
// ----------------------------------------------------------------------------
// ffe_out_if
// Result channel: one decoded value byte with its status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       byte_valid;
  logic       field_found;
  logic       data_done;

  modport source (output valid, output value_byte, output byte_valid,
                  output field_found, output data_done, input ready);
  modport sink   (input valid, input value_byte, input byte_valid,
                  input field_found, input data_done, output ready);
endinterface

`default_nettype wire

/* sv/ffe_cfg_if.sv */
// ----------------------------------------------------------------------------
// ffe_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffe_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ffe_pkg::CFG_IDX_W-1:0] index;
  logic [ffe_pkg::NAME_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/ffe_front.sv */
// ----------------------------------------------------------------------------
// ffe_front
// Accepts form bytes, tracks segment and name matching, decodes escapes and
// packs the decoded bytes of each input byte into one job for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ffe_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  ffe_cfg_if.sink            cfg_if,
  ffe_in_if.sink             in_if,
  input  wire logic          q_ready,
  output logic               q_push,
  output ffe_pkg::job_t      q_job
);

  logic [ffe_pkg::NAME_W-1:0]     field_name_r;
  logic [ffe_pkg::NAME_LEN_W-1:0] field_len_r;
  logic [ffe_pkg::LIMIT_W-1:0]    value_limit_r;

  ffe_pkg::phase_t                phase_r, phase_nxt;
  logic [ffe_pkg::NAME_POS_W-1:0] pos_r, pos_nxt;
  ffe_pkg::esc_t                  esc_r, esc_nxt;
  logic [7:0]                     held_r, held_nxt;
  logic [ffe_pkg::ENC_CNT_W-1:0]  enc_r, enc_nxt;
  logic [ffe_pkg::LIMIT_W-1:0]    emitted_r, emitted_nxt;
  logic                           found_r, found_nxt;

  logic [3:0][7:0]                items;
  logic [ffe_pkg::RES_CNT_W-1:0]  n;
  logic [ffe_pkg::RES_CNT_W-1:0]  take;
  logic [ffe_pkg::LIMIT_W-1:0]    avail;
  logic [ffe_pkg::NAME_LEN_W-1:0] nlen;
  logic [4:0]                     hb, hh;
  logic                           do_flush, tail;
  logic [7:0]                     b;
  logic                           accept;

  assign b            = in_if.data_byte;
  assign in_if.ready  = q_ready;
  assign accept       = in_if.valid && q_ready;
  assign cfg_if.ready = 1'b1;

  assign nlen = (field_len_r > ffe_pkg::NAME_LEN_MAX) ? ffe_pkg::NAME_LEN_MAX : field_len_r;
  assign hb   = ffe_pkg::hex_decode(b);
  assign hh   = ffe_pkg::hex_decode(held_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_name_r  <= ffe_pkg::FIELD_NAME_RST;
      field_len_r   <= ffe_pkg::NAME_LEN_RST;
      value_limit_r <= ffe_pkg::VALUE_LIMIT_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        ffe_pkg::REG_FIELD_NAME:  field_name_r  <= cfg_if.data;
        ffe_pkg::REG_NAME_LENGTH: field_len_r   <= cfg_if.data[ffe_pkg::NAME_LEN_W-1:0];
        ffe_pkg::REG_VALUE_LIMIT: value_limit_r <= cfg_if.data[ffe_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    esc_nxt   = esc_r;
    held_nxt  = held_r;
    enc_nxt   = enc_r;
    found_nxt = found_r;
    items     = '0;
    n         = '0;
    do_flush  = 1'b0;
    tail      = 1'b0;

    case (phase_r)
      ffe_pkg::PH_NAME: begin
        if (b == ffe_pkg::CH_AMP) begin
          pos_nxt = '0;
        end else if (pos_r < nlen && b == field_name_r[pos_r[2:0]*8 +: 8]) begin
          pos_nxt = pos_r + 1'b1;
        end else if (pos_r == nlen && b == ffe_pkg::CH_EQUALS) begin
          found_nxt = 1'b1;
          phase_nxt = ffe_pkg::PH_VALUE;
        end else begin
          phase_nxt = ffe_pkg::PH_SKIP;
        end
      end
      ffe_pkg::PH_VALUE: begin
        if (b == ffe_pkg::CH_AMP) begin
          do_flush  = 1'b1;
          phase_nxt = ffe_pkg::PH_DONE;
        end else if (enc_r < ffe_pkg::ENC_MAX) begin
          enc_nxt = enc_r + 1'b1;
          tail    = 1'b1;
          case (esc_r)
            ffe_pkg::ESC_HEX1: begin
              if (hb[4]) begin
                items[0] = {hh[3:0], hb[3:0]};
                n        = 2'd1;
                esc_nxt  = ffe_pkg::ESC_NONE;
                tail     = 1'b0;
              end else begin
                // broken escape: pass '%' and the held digit through
                items[0] = ffe_pkg::CH_PERCENT;
                items[1] = held_r;
                n        = 2'd2;
                esc_nxt  = ffe_pkg::ESC_NONE;
              end
            end
            ffe_pkg::ESC_PCT: begin
              if (hb[4]) begin
                held_nxt = b;
                esc_nxt  = ffe_pkg::ESC_HEX1;
                tail     = 1'b0;
              end else begin
                items[0] = ffe_pkg::CH_PERCENT;
                n        = 2'd1;
                esc_nxt  = ffe_pkg::ESC_NONE;
              end
            end
            default: esc_nxt = ffe_pkg::ESC_NONE;
          endcase
          if (tail) begin
            if (b == ffe_pkg::CH_PLUS) begin
              items[n] = ffe_pkg::CH_SPACE;
              n        = n + 1'b1;
            end else if (b == ffe_pkg::CH_PERCENT) begin
              esc_nxt = ffe_pkg::ESC_PCT;
            end else begin
              items[n] = b;
              n        = n + 1'b1;
            end
          end
        end
      end
      ffe_pkg::PH_SKIP: begin
        if (b == ffe_pkg::CH_AMP) begin
          phase_nxt = ffe_pkg::PH_NAME;
          pos_nxt   = '0;
        end
      end
      default: ;
    endcase

    if (in_if.last_byte && phase_nxt == ffe_pkg::PH_VALUE) begin
      do_flush  = 1'b1;
      phase_nxt = ffe_pkg::PH_DONE;
    end

    // end of value: release any pending escape characters
    if (do_flush) begin
      case (esc_nxt)
        ffe_pkg::ESC_PCT: begin
          items[n] = ffe_pkg::CH_PERCENT;
          n        = n + 1'b1;
        end
        ffe_pkg::ESC_HEX1: begin
          items[n]              = ffe_pkg::CH_PERCENT;
          items[2'(n + 2'd1)]   = held_nxt;
          n                     = n + 2'd2;
        end
        default: ;
      endcase
      esc_nxt = ffe_pkg::ESC_NONE;
    end
  end

  // decoded bytes past the limit are dropped
  assign avail       = (emitted_r >= value_limit_r) ? '0 : value_limit_r - emitted_r;
  assign take        = (avail >= ffe_pkg::LIMIT_W'(n)) ? n : avail[ffe_pkg::RES_CNT_W-1:0];
  assign emitted_nxt = emitted_r + ffe_pkg::LIMIT_W'(take);

  assign q_job.bytes = items[ffe_pkg::MAX_RES-1:0];
  assign q_job.cnt   = take;
  assign q_job.found = found_nxt;
  assign q_job.done  = in_if.last_byte;
  assign q_push      = accept && (take != '0 || in_if.last_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= ffe_pkg::PH_NAME;
      pos_r     <= '0;
      esc_r     <= ffe_pkg::ESC_NONE;
      held_r    <= '0;
      enc_r     <= '0;
      emitted_r <= '0;
      found_r   <= 1'b0;
    end else if (accept) begin
      if (in_if.last_byte) begin
        phase_r   <= ffe_pkg::PH_NAME;
        pos_r     <= '0;
        esc_r     <= ffe_pkg::ESC_NONE;
        held_r    <= '0;
        enc_r     <= '0;
        emitted_r <= '0;
        found_r   <= 1'b0;
      end else begin
        phase_r   <= phase_nxt;
        pos_r     <= pos_nxt;
        esc_r     <= esc_nxt;
        held_r    <= held_nxt;
        enc_r     <= enc_nxt;
        emitted_r <= emitted_nxt;
        found_r   <= found_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/ffe_queue.sv */
// ----------------------------------------------------------------------------
// ffe_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module ffe_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ffe_pkg::job_t push_job,
  output logic               push_ready,
  input  wire logic          pop,
  output logic               head_valid,
  output ffe_pkg::job_t      head_job
);

  ffe_pkg::job_t               mem_r [ffe_pkg::QUEUE_DEPTH];
  logic [ffe_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [ffe_pkg::QCNT_W-1:0]  cnt_r;
  logic                        do_push, do_pop;

  assign push_ready = cnt_r != ffe_pkg::QCNT_W'(ffe_pkg::QUEUE_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == ffe_pkg::QPTR_W'(ffe_pkg::QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == ffe_pkg::QPTR_W'(ffe_pkg::QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/ffe_back.sv */
// ----------------------------------------------------------------------------
// ffe_back
// Unpacks each job into one result transfer per decoded byte, or a single
// empty end marker, held in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffe_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire ffe_pkg::job_t q_job,
  output logic               q_pop,
  ffe_out_if.source          out_if
);

  ffe_pkg::job_t                 job_r;
  logic [ffe_pkg::RES_CNT_W-1:0] pos_r;
  logic                          busy_r;
  logic                          is_last, take_out, load, empty_job;

  assign empty_job = job_r.cnt == '0;
  assign is_last   = empty_job || (pos_r == job_r.cnt - 1'b1);
  assign take_out  = busy_r && out_if.ready;
  assign load      = q_valid && (!busy_r || (take_out && is_last));
  assign q_pop     = load;

  assign out_if.valid       = busy_r;
  assign out_if.value_byte  = empty_job ? 8'h00 : job_r.bytes[pos_r];
  assign out_if.byte_valid  = !empty_job;
  assign out_if.field_found = job_r.found;
  assign out_if.data_done   = job_r.done && is_last;

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      pos_r  <= '0;
    end else if (take_out) begin
      if (is_last) begin
        busy_r <= 1'b0;
      end else begin
        pos_r <= pos_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/form_field_extract_url_decode.sv */
// ----------------------------------------------------------------------------
// form_field_extract_url_decode
// Picks the named field out of a URL-encoded form body and streams its
// decoded value.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                         | transfer
//  cfg_if   | in  | index[1:0], data[63:0]                          | valid & ready
//  in_if    | in  | data_byte[7:0], last_byte                       | valid & ready
//  out_if   | out | value_byte[7:0], byte_valid, field_found, done  | valid & ready
//
//  One input byte is taken every cycle while the four-entry job queue has room.
//  Each byte gives zero to three results; the back end sends one per cycle
//  while out_if is ready; when results outpace it, the full queue stalls input.
//  A byte's first result passes through the queue, then the output register.
//  rst_n is synchronous; no clearing pass, input is ready on the cycle after reset.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module form_field_extract_url_decode (
  input  wire logic clk,
  input  wire logic rst_n,
  ffe_cfg_if.sink   cfg_if,
  ffe_in_if.sink    in_if,
  ffe_out_if.source out_if
);

  logic          q_push, q_ready, q_valid, q_pop;
  ffe_pkg::job_t push_job, head_job;

  ffe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_if  (cfg_if),
    .in_if   (in_if),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_job   (push_job)
  );

  ffe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  ffe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (head_job),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

`default_nettype wire
